FILE: rtl/ets_pkg.sv
// Shared types and constants for the expression token scanner.
// Holds scan modes, token kinds, character codes and the token record.
// Depends on nothing.
package ets_pkg;

	typedef enum logic [4:0] {
		MODE_IDLE   = 5'b00001,
		MODE_SPACE  = 5'b00010,
		MODE_NUMBER = 5'b00100,
		MODE_IDENT  = 5'b01000,
		MODE_DOT    = 5'b10000
	} mode_t;

	localparam logic [2:0] KIND_SPACE    = 3'd0;
	localparam logic [2:0] KIND_NUMBER   = 3'd1;
	localparam logic [2:0] KIND_IDENT    = 3'd2;
	localparam logic [2:0] KIND_OPERATOR = 3'd3;
	localparam logic [2:0] KIND_UNKNOWN  = 3'd4;

	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_LPAR   = 8'h28;
	localparam logic [7:0] CH_RPAR   = 8'h29;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_Z   = 8'h5A;
	localparam logic [7:0] CH_LO_A   = 8'h61;
	localparam logic [7:0] CH_LO_Z   = 8'h7A;

	localparam logic [15:0] LEN_MAX = 16'hFFFF;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] start;
		logic [15:0] length;
		logic [7:0]  single_char;
		logic [63:0] mantissa;
		logic [15:0] frac;
		logic        ovf;
		logic        last_of_run;
		logic        done;
	} tok_t;

endpackage

FILE: rtl/expression_token_scanner_unit.sv
// Expression token scanner top level: character classifier, token state and result queue.
// Depends on ets_pkg.
//
// Takes one character per cycle and cuts the stream into space, number, identifier,
// operator and unrecognized tokens. A character is registered on acceptance, goes
// through the scanner logic and its tokens land in a four-entry result queue, whose
// occupancy drives token_valid. Most characters give zero or one token; one that
// closes a token and is itself an operator or unrecognized, or the last character,
// may give two. Such a character leaves nothing open, so the next one gives at most
// one. The input stalls only while more than two results wait in the queue, so with
// a free-running consumer the input never stalls and the block sustains one character
// per cycle. Numbers come out as a 64-bit decimal mantissa and a count of fraction
// digits; positions count in POSITION_BITS bits and saturate.
module expression_token_scanner_unit #(
	parameter int POSITION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_stall,
	input  logic [7:0]  character,
	input  logic        last_char,
	output logic        token_valid,
	input  logic        token_stall,
	output logic [2:0]  token_kind,
	output logic [15:0] token_start,
	output logic [15:0] token_length,
	output logic [7:0]  single_char,
	output logic [63:0] number_mantissa,
	output logic [15:0] fraction_digits,
	output logic        overflow,
	output logic        last_of_run,
	output logic        expression_done
);

	localparam int P = POSITION_BITS;
	localparam int W = (P + 1 > 17) ? P + 1 : 17;
	localparam logic [W-1:0] LIM16 = W'(17'h0FFFF);

	// Builds one token record; lengths and positions saturate to 16 bits.
	function automatic ets_pkg::tok_t make_tok(input logic [2:0] kind,
			input logic [P-1:0] tbeg, input logic [P:0] tend, input logic [7:0] ch,
			input logic [63:0] acc, input logic [15:0] frac, input logic num_of,
			input logic pos_sat);
		ets_pkg::tok_t t;
		logic [P:0]   len_w;
		logic [W-1:0] len_x;
		logic [W-1:0] beg_x;
		logic         is_num;
		logic         is_chr;
		is_num = (kind == ets_pkg::KIND_NUMBER);
		is_chr = (kind == ets_pkg::KIND_OPERATOR) || (kind == ets_pkg::KIND_UNKNOWN);
		len_w = (tend > {1'b0, tbeg}) ? (tend - {1'b0, tbeg}) : (P + 1)'(1);
		len_x = W'(len_w);
		beg_x = W'(tbeg);
		t.kind        = kind;
		t.start       = (beg_x > LIM16) ? ets_pkg::LEN_MAX : beg_x[15:0];
		t.length      = (len_x > LIM16) ? ets_pkg::LEN_MAX : len_x[15:0];
		t.single_char = is_chr ? ch : 8'h00;
		t.mantissa    = is_num ? acc : 64'd0;
		t.frac        = is_num ? frac : 16'd0;
		t.ovf         = pos_sat | (len_x > LIM16) | (beg_x > LIM16) | (is_num & num_of);
		t.last_of_run = 1'b0;
		t.done        = 1'b0;
		return t;
	endfunction

	// Token for whatever is open in the given mode.
	function automatic ets_pkg::tok_t close_tok(input ets_pkg::mode_t mode,
			input logic [P-1:0] tbeg, input logic [P:0] tend, input logic [63:0] acc,
			input logic [15:0] frac, input logic num_of, input logic pos_sat);
		ets_pkg::tok_t t;
		case (mode)
			ets_pkg::MODE_NUMBER: begin
				t = make_tok(ets_pkg::KIND_NUMBER, tbeg, tend, 8'h00, acc, frac, num_of,
					pos_sat);
			end
			ets_pkg::MODE_IDENT: begin
				t = make_tok(ets_pkg::KIND_IDENT, tbeg, tend, 8'h00, acc, frac, num_of,
					pos_sat);
			end
			ets_pkg::MODE_DOT: begin
				// lone dot: one character, unrecognized
				t = make_tok(ets_pkg::KIND_UNKNOWN, tbeg, {1'b0, tbeg} + (P + 1)'(1),
					ets_pkg::CH_DOT, acc, frac, num_of, pos_sat);
			end
			default: begin
				t = make_tok(ets_pkg::KIND_SPACE, tbeg, tend, 8'h00, acc, frac, num_of,
					pos_sat);
			end
		endcase
		return t;
	endfunction

	// input register
	logic [7:0]        char_s1;
	logic              last_s1;
	logic              valid_s1;

	// scanner state
	ets_pkg::mode_t    mode_q;
	logic [P-1:0]      pos_q;
	logic [P-1:0]      beg_q;
	logic              dot_q;
	logic [63:0]       acc_q;
	logic [15:0]       frac_q;
	logic              of_q;

	// result queue
	ets_pkg::tok_t     fifo_q [4];
	logic [1:0]        wr_ptr_q;
	logic [1:0]        rd_ptr_q;
	logic [2:0]        count_q;

	logic              fire;
	logic              pop;

	ets_pkg::mode_t    mode_n;
	logic [P-1:0]      pos_n;
	logic [P-1:0]      beg_n;
	logic              dot_n;
	logic [63:0]       acc_n;
	logic [15:0]       frac_n;
	logic              of_n;
	ets_pkg::tok_t     r0;
	ets_pkg::tok_t     r1;
	logic              v0;
	logic              v1;
	ets_pkg::tok_t     push0;
	ets_pkg::tok_t     push1;
	logic [1:0]        npush;

	// digit accumulate inputs and result
	logic              add_en;
	logic [63:0]       ad_acc;
	logic [15:0]       ad_frac;
	logic              ad_of;
	logic              ad_dot;
	logic [67:0]       prod;
	logic [63:0]       add_acc;
	logic [15:0]       add_frac;
	logic              add_of;

	logic              is_dig;
	logic              is_sp;
	logic              is_ids;
	logic              is_idp;
	logic              is_op;
	logic              taken;
	logic              pos_sat;
	logic [P:0]        pos_p1;

	assign fire       = valid_s1 && (count_q <= 3'd2);
	assign char_stall = valid_s1 && !fire;
	assign token_valid = (count_q != 3'd0);
	assign pop        = token_valid && !token_stall;

	assign token_kind      = fifo_q[rd_ptr_q].kind;
	assign token_start     = fifo_q[rd_ptr_q].start;
	assign token_length    = fifo_q[rd_ptr_q].length;
	assign single_char     = fifo_q[rd_ptr_q].single_char;
	assign number_mantissa = fifo_q[rd_ptr_q].mantissa;
	assign fraction_digits = fifo_q[rd_ptr_q].frac;
	assign overflow        = fifo_q[rd_ptr_q].ovf;
	assign last_of_run     = fifo_q[rd_ptr_q].last_of_run;
	assign expression_done = fifo_q[rd_ptr_q].done;

	always_comb begin
		is_dig = (char_s1 >= ets_pkg::CH_ZERO) && (char_s1 <= ets_pkg::CH_NINE);
		is_sp  = (char_s1 == ets_pkg::CH_SPACE) || (char_s1 == ets_pkg::CH_TAB) ||
			(char_s1 == ets_pkg::CH_LF) || (char_s1 == ets_pkg::CH_CR);
		is_ids = ((char_s1 >= ets_pkg::CH_UP_A) && (char_s1 <= ets_pkg::CH_UP_Z)) ||
			((char_s1 >= ets_pkg::CH_LO_A) && (char_s1 <= ets_pkg::CH_LO_Z)) ||
			(char_s1 == ets_pkg::CH_UNDER);
		is_idp = is_ids || is_dig;
		is_op  = (char_s1 == ets_pkg::CH_PLUS) || (char_s1 == ets_pkg::CH_MINUS) ||
			(char_s1 == ets_pkg::CH_STAR) || (char_s1 == ets_pkg::CH_SLASH) ||
			(char_s1 == ets_pkg::CH_CARET) || (char_s1 == ets_pkg::CH_PCT) ||
			(char_s1 == ets_pkg::CH_EQ) || (char_s1 == ets_pkg::CH_LPAR) ||
			(char_s1 == ets_pkg::CH_RPAR) || (char_s1 == ets_pkg::CH_COMMA);
		pos_sat = (pos_q == {P{1'b1}});
		pos_p1  = {1'b0, pos_q} + (P + 1)'(1);
	end

	always_comb begin
		taken   = 1'b0;
		mode_n  = mode_q;
		beg_n   = beg_q;
		dot_n   = dot_q;
		add_en  = 1'b0;
		ad_acc  = acc_q;
		ad_frac = frac_q;
		ad_of   = of_q;
		ad_dot  = dot_q;
		v0      = 1'b0;
		v1      = 1'b0;
		r0      = close_tok(mode_q, beg_q, {1'b0, pos_q}, acc_q, frac_q, of_q, pos_sat);
		r1      = r0;

		case (mode_q)
			ets_pkg::MODE_SPACE: begin
				taken = is_sp;
			end
			ets_pkg::MODE_NUMBER: begin
				if (is_dig) begin
					add_en = 1'b1;
					taken  = 1'b1;
				end else if ((char_s1 == ets_pkg::CH_DOT) && !dot_q) begin
					dot_n = 1'b1;
					taken = 1'b1;
				end
			end
			ets_pkg::MODE_IDENT: begin
				taken = is_idp;
			end
			ets_pkg::MODE_DOT: begin
				if (is_dig) begin
					mode_n  = ets_pkg::MODE_NUMBER;
					dot_n   = 1'b1;
					add_en  = 1'b1;
					ad_acc  = 64'd0;
					ad_frac = 16'd0;
					ad_of   = 1'b0;
					ad_dot  = 1'b1;
					taken   = 1'b1;
				end
			end
			default: begin
			end
		endcase

		if (!taken) begin
			v0    = (mode_q != ets_pkg::MODE_IDLE);
			beg_n = pos_q;
			if (is_sp) begin
				mode_n = ets_pkg::MODE_SPACE;
			end else if (is_dig) begin
				mode_n  = ets_pkg::MODE_NUMBER;
				dot_n   = 1'b0;
				add_en  = 1'b1;
				ad_acc  = 64'd0;
				ad_frac = 16'd0;
				ad_of   = 1'b0;
				ad_dot  = 1'b0;
			end else if (char_s1 == ets_pkg::CH_DOT) begin
				mode_n = ets_pkg::MODE_DOT;
			end else if (is_ids) begin
				mode_n = ets_pkg::MODE_IDENT;
			end else begin
				mode_n = ets_pkg::MODE_IDLE;
				v1     = 1'b1;
				r1     = make_tok(is_op ? ets_pkg::KIND_OPERATOR : ets_pkg::KIND_UNKNOWN,
					pos_q, pos_p1, char_s1, acc_q, frac_q, of_q, pos_sat);
			end
		end

		// decimal accumulate: acc*10 + d, saturating
		prod = ({4'd0, ad_acc} << 3) + ({4'd0, ad_acc} << 1) + 68'(char_s1[3:0]);
		if (prod[67:64] != 4'd0) begin
			add_acc = {64{1'b1}};
			add_of  = 1'b1;
		end else begin
			add_acc = prod[63:0];
			add_of  = ad_of;
		end
		add_frac = ad_frac;
		if (ad_dot) begin
			if (ad_frac == ets_pkg::LEN_MAX) begin
				add_of = 1'b1;
			end else begin
				add_frac = ad_frac + 16'd1;
			end
		end
		acc_n  = add_en ? add_acc : acc_q;
		frac_n = add_en ? add_frac : frac_q;
		of_n   = add_en ? add_of : of_q;

		// end of expression flushes the open token; an operator leaves nothing open
		if (last_s1) begin
			if (mode_n != ets_pkg::MODE_IDLE) begin
				v1 = 1'b1;
				r1 = close_tok(mode_n, beg_n, pos_p1, acc_n, frac_n, of_n, pos_sat);
			end
			mode_n = ets_pkg::MODE_IDLE;
			pos_n  = '0;
		end else begin
			pos_n = pos_sat ? pos_q : pos_p1[P-1:0];
		end

		push0 = v0 ? r0 : r1;
		push1 = r1;
		npush = {1'b0, v0} + {1'b0, v1};
		if (v0 && v1) begin
			push1.last_of_run = 1'b1;
			push1.done        = last_s1;
		end else begin
			push0.last_of_run = 1'b1;
			push0.done        = last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_valid && !char_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && !char_stall) begin
			char_s1 <= character;
			last_s1 <= last_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ets_pkg::MODE_IDLE;
			pos_q  <= '0;
			beg_q  <= '0;
			dot_q  <= 1'b0;
			acc_q  <= 64'd0;
			frac_q <= 16'd0;
			of_q   <= 1'b0;
		end else if (fire) begin
			mode_q <= mode_n;
			pos_q  <= pos_n;
			beg_q  <= beg_n;
			dot_q  <= dot_n;
			acc_q  <= acc_n;
			frac_q <= frac_n;
			of_q   <= of_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			count_q  <= 3'd0;
		end else begin
			if (fire) begin
				wr_ptr_q <= wr_ptr_q + npush;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			count_q <= count_q + (fire ? {1'b0, npush} : 3'd0) - {2'd0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (fire && (npush != 2'd0)) begin
			fifo_q[wr_ptr_q] <= push0;
		end
		if (fire && (npush == 2'd2)) begin
			fifo_q[wr_ptr_q + 2'd1] <= push1;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'd4)
		else $error("result queue count out of range");

	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last_s1 |-> npush != 2'd0)
		else $error("last character produced no token");

	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last_s1 |=> pos_q == '0 && mode_q == ets_pkg::MODE_IDLE)
		else $error("scanner not idle after end of expression");

	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && count_q > 3'd2 |-> char_stall)
		else $error("request taken with no room for two results");
`endif

endmodule

FILE: bench/tb_token_pkg.sv
`timescale 1ns / 100ps
// Token bookkeeping for the expression token scanner bench: a bit-level predictor
// of the scanner and the queue of tokens still awaited from the block.
// Depends on ets_pkg.
package tb_token_pkg;
	import ets_pkg::*;

	localparam int SCAN_POS_BITS = 16;
	localparam logic [63:0] POS_LIMIT = (64'd1 << SCAN_POS_BITS) - 64'd1;
	localparam logic [63:0] MANT_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] MANT_TENTH = MANT_MAX / 64'd10;
	localparam logic [63:0] MANT_LAST = MANT_MAX % 64'd10;
	localparam logic [63:0] FIELD_MAX = 64'hFFFF;

	class token_ledger;
		mode_t       mode;
		logic [63:0] cur_pos;
		logic [63:0] tok_begin;
		bit          dot_taken;
		logic [63:0] mant;
		logic [31:0] frac_cnt;
		bit          num_ovf;
		tok_t        step_toks[$];
		tok_t        due_tokens[$];
		int          mismatches;

		function new();
			mode = MODE_IDLE;
			cur_pos = '0;
			tok_begin = '0;
			dot_taken = 1'b0;
			mant = '0;
			frac_cnt = '0;
			num_ovf = 1'b0;
			mismatches = 0;
		endfunction

		static function bit is_digit(logic [7:0] c);
			return c >= CH_ZERO && c <= CH_NINE;
		endfunction

		static function bit is_id_start(logic [7:0] c);
			return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z) ||
				c == CH_UNDER;
		endfunction

		static function bit is_space(logic [7:0] c);
			return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
		endfunction

		static function bit is_operator(logic [7:0] c);
			return c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
				c == CH_CARET || c == CH_PCT || c == CH_EQ || c == CH_LPAR ||
				c == CH_RPAR || c == CH_COMMA;
		endfunction

		function void add_digit(logic [7:0] c);
			logic [63:0] d;
			d = {56'd0, c - CH_ZERO};
			if (mant > MANT_TENTH || (mant == MANT_TENTH && d > MANT_LAST)) begin
				mant = MANT_MAX;
				num_ovf = 1'b1;
			end else begin
				mant = mant * 64'd10 + d;
			end
			if (dot_taken) begin
				if (frac_cnt >= 32'hFFFF)
					num_ovf = 1'b1;
				else
					frac_cnt++;
			end
		endfunction

		function void start_number(bit with_dot, logic [7:0] c);
			dot_taken = with_dot;
			mant = '0;
			frac_cnt = '0;
			num_ovf = 1'b0;
			add_digit(c);
		endfunction

		// ovf looks at the position before this request moves it
		function void make_token(logic [2:0] kind, logic [63:0] first_pos,
				logic [63:0] end_pos, logic [7:0] c);
			tok_t t;
			logic [63:0] len;
			bit ovf;
			len = (end_pos > first_pos) ? end_pos - first_pos : 64'd1;
			ovf = (cur_pos == POS_LIMIT);
			if (len > FIELD_MAX) begin
				len = FIELD_MAX;
				ovf = 1'b1;
			end
			if (first_pos > FIELD_MAX) begin
				first_pos = FIELD_MAX;
				ovf = 1'b1;
			end
			t.kind = kind;
			t.start = first_pos[15:0];
			t.length = len[15:0];
			t.single_char = (kind == KIND_OPERATOR || kind == KIND_UNKNOWN) ? c : 8'd0;
			t.mantissa = (kind == KIND_NUMBER) ? mant : 64'd0;
			t.frac = (kind == KIND_NUMBER) ? frac_cnt[15:0] : 16'd0;
			if (kind == KIND_NUMBER && num_ovf)
				ovf = 1'b1;
			t.ovf = ovf;
			t.last_of_run = 1'b0;
			t.done = 1'b0;
			step_toks.push_back(t);
		endfunction

		function void close_open(logic [63:0] end_pos);
			case (mode)
				MODE_SPACE: make_token(KIND_SPACE, tok_begin, end_pos, 8'd0);
				MODE_NUMBER: make_token(KIND_NUMBER, tok_begin, end_pos, 8'd0);
				MODE_IDENT: make_token(KIND_IDENT, tok_begin, end_pos, 8'd0);
				MODE_DOT: make_token(KIND_UNKNOWN, tok_begin, tok_begin + 64'd1, CH_DOT);
				default: ;
			endcase
			mode = MODE_IDLE;
		endfunction

		function void note_char(logic [7:0] c, bit last);
			logic [63:0] pos;
			bit taken;
			tok_t t;
			pos = cur_pos;
			taken = 1'b0;
			step_toks.delete();
			case (mode)
				MODE_SPACE: taken = is_space(c);
				MODE_NUMBER: begin
					if (is_digit(c)) begin
						add_digit(c);
						taken = 1'b1;
					end else if (c == CH_DOT && !dot_taken) begin
						dot_taken = 1'b1;
						taken = 1'b1;
					end
				end
				MODE_IDENT: taken = is_id_start(c) || is_digit(c);
				MODE_DOT: begin
					if (is_digit(c)) begin
						mode = MODE_NUMBER;
						start_number(1'b1, c);
						taken = 1'b1;
					end
				end
				default: ;
			endcase
			if (!taken) begin
				close_open(pos);
				tok_begin = pos;
				if (is_space(c)) begin
					mode = MODE_SPACE;
				end else if (is_digit(c)) begin
					mode = MODE_NUMBER;
					start_number(1'b0, c);
				end else if (c == CH_DOT) begin
					mode = MODE_DOT;
				end else if (is_id_start(c)) begin
					mode = MODE_IDENT;
				end else if (is_operator(c)) begin
					make_token(KIND_OPERATOR, pos, pos + 64'd1, c);
				end else begin
					make_token(KIND_UNKNOWN, pos, pos + 64'd1, c);
				end
			end
			if (last) begin
				close_open(pos + 64'd1);
				cur_pos = '0;
			end else begin
				cur_pos = (pos < POS_LIMIT) ? pos + 64'd1 : POS_LIMIT;
			end
			if (step_toks.size() > 0) begin
				t = step_toks.pop_back();
				t.last_of_run = 1'b1;
				t.done = last;
				step_toks.push_back(t);
			end
			foreach (step_toks[i])
				due_tokens.push_back(step_toks[i]);
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$display("%0t: %s expected %0d got %0d", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void check_token(tok_t got);
			tok_t want;
			if (due_tokens.size() == 0) begin
				$display("%0t: token_kind expected none got %0d (start %0d)", $time,
					got.kind, got.start);
				mismatches++;
				return;
			end
			want = due_tokens.pop_front();
			compare_field("token_kind", want.kind, got.kind);
			compare_field("token_start", want.start, got.start);
			compare_field("token_length", want.length, got.length);
			compare_field("single_char", want.single_char, got.single_char);
			compare_field("number_mantissa", want.mantissa, got.mantissa);
			compare_field("fraction_digits", want.frac, got.frac);
			compare_field("overflow", want.ovf, got.ovf);
			compare_field("last_of_run", want.last_of_run, got.last_of_run);
			compare_field("expression_done", want.done, got.done);
		endfunction
	endclass

endpackage

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// Top of the expression token scanner bench: clock, reset, request driver,
// token receiver with its stall patterns, watchdog and end of run.
// Depends on ets_pkg, tb_token_pkg and expression_token_scanner_unit.
module tb_top;
	import ets_pkg::*;
	import tb_token_pkg::*;

	localparam int RANDOM_CHARS = 1300;
	localparam int IDLE_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int LONG_RUN = 40;

	localparam logic [7:0] SPACE_CHARS [4] = '{CH_SPACE, CH_TAB, CH_LF, CH_CR};
	localparam logic [7:0] OP_CHARS [10] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
		CH_CARET, CH_PCT, CH_EQ, CH_LPAR, CH_RPAR, CH_COMMA};

	typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_BEAT} rx_style_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        char_valid = 1'b0;
	logic        char_stall;
	logic [7:0]  character = 8'd0;
	logic        last_char = 1'b0;
	logic        token_valid;
	logic        token_stall = 1'b0;
	logic [2:0]  token_kind;
	logic [15:0] token_start;
	logic [15:0] token_length;
	logic [7:0]  single_char;
	logic [63:0] number_mantissa;
	logic [15:0] fraction_digits;
	logic        overflow;
	logic        last_of_run;
	logic        expression_done;

	token_ledger ledger;
	tok_t        seen_tok;
	logic [7:0]  expr_buf[$];
	bit          hold_go = 1'b0;
	bit          hold_off = 1'b0;
	bit          gaps_on = 1'b1;
	int          burst_left = 0;
	int          rx_cycle = 0;
	int          idle_cycles = 0;
	rx_style_t   rx_style = RX_FREE;

	expression_token_scanner_unit #(
		.POSITION_BITS(SCAN_POS_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.character(character),
		.last_char(last_char),
		.token_valid(token_valid),
		.token_stall(token_stall),
		.token_kind(token_kind),
		.token_start(token_start),
		.token_length(token_length),
		.single_char(single_char),
		.number_mantissa(number_mantissa),
		.fraction_digits(fraction_digits),
		.overflow(overflow),
		.last_of_run(last_of_run),
		.expression_done(expression_done)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver: checks accepted tokens, then picks next cycle's stall
	always @(posedge clk) begin
		if (arst_n && token_valid && !token_stall) begin
			seen_tok = {token_kind, token_start, token_length, single_char, number_mantissa,
				fraction_digits, overflow, last_of_run, expression_done};
			ledger.check_token(seen_tok);
		end
		rx_cycle++;
		if (rx_cycle % 200 == 0)
			rx_style = rx_style_t'($urandom_range(0, 3));
		if (hold_off) begin
			token_stall <= 1'b1;
		end else begin
			case (rx_style)
				RX_FREE: token_stall <= 1'b0;
				RX_LIGHT: token_stall <= ($urandom_range(0, 3) == 0);
				RX_HEAVY: token_stall <= ($urandom_range(0, 3) != 0);
				default: token_stall <= (rx_cycle % 5 < 2);
			endcase
		end
	end

	// long hold-off so the result queue fills and the input backs up
	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n || (char_valid && !char_stall) || (token_valid && !token_stall)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	task automatic send_char(input logic [7:0] c, input bit last);
		char_valid <= 1'b1;
		character <= c;
		last_char <= last;
		do @(posedge clk); while (char_stall);
		ledger.note_char(c, last);
	endtask

	task automatic pause_sender(input int n);
		char_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic put_char(input logic [7:0] c, input bit last);
		int gap;
		if (burst_left == 0) begin
			gap = gaps_on ? $urandom_range(0, 6) : 0;
			if (gap > 0)
				pause_sender(gap);
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		send_char(c, last);
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put_char(s[i], i == s.len() - 1);
	endtask

	function automatic logic [7:0] pick_digit();
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] pick_id_start();
		int r;
		r = $urandom_range(0, 52);
		if (r < 26)
			return CH_UP_A + 8'(r);
		if (r < 52)
			return CH_LO_A + 8'(r - 26);
		return CH_UNDER;
	endfunction

	// mostly well-formed tokens, with lone dots and raw bytes as noise
	task automatic build_expression();
		int len;
		bit lead_dot;
		expr_buf.delete();
		repeat ($urandom_range(1, 12)) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					lead_dot = ($urandom_range(0, 5) == 0);
					if (lead_dot)
						expr_buf.push_back(CH_DOT);
					len = ($urandom_range(0, 12) == 0) ? $urandom_range(19, 24) :
						$urandom_range(1, 6);
					repeat (len) expr_buf.push_back(pick_digit());
					if (!lead_dot && $urandom_range(0, 2) == 0) begin
						expr_buf.push_back(CH_DOT);
						repeat ($urandom_range(0, 4)) expr_buf.push_back(pick_digit());
					end
					if ($urandom_range(0, 9) == 0)
						expr_buf.push_back(CH_DOT);
				end
				2, 3: begin
					expr_buf.push_back(pick_id_start());
					repeat ($urandom_range(0, 8))
						expr_buf.push_back(($urandom_range(0, 3) == 0) ? pick_digit() :
							pick_id_start());
				end
				4, 5: begin
					repeat ($urandom_range(1, 3))
						expr_buf.push_back(SPACE_CHARS[$urandom_range(0, 3)]);
				end
				6, 7: expr_buf.push_back(OP_CHARS[$urandom_range(0, 9)]);
				8: expr_buf.push_back(CH_DOT);
				default: expr_buf.push_back(8'($urandom_range(0, 255)));
			endcase
		end
	endtask

	initial begin
		int sent;
		ledger = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// trailing dot, leading dot, lone dot, second dot, dot as last char
		put_text("3.");
		put_text(".5");
		put_text(".+");
		put_text("1.2.3");
		put_text(".");
		put_char(8'h00, 1'b0);
		put_char(8'hFF, 1'b1);
		put_text("_Zz9\t\r\n(=");

		sent = 0;
		while (sent < RANDOM_CHARS) begin
			build_expression();
			if (sent >= RANDOM_CHARS / 3)
				hold_go <= 1'b1;
			foreach (expr_buf[i])
				put_char(expr_buf[i], i == expr_buf.size() - 1);
			sent += expr_buf.size();
		end

		// long fraction part, back to back, so the mantissa saturates
		gaps_on = 1'b0;
		put_char(CH_ZERO, 1'b0);
		put_char(CH_DOT, 1'b0);
		repeat (LONG_RUN) put_char(pick_digit(), 1'b0);
		put_char(pick_digit(), 1'b1);
		put_text("a\t");
		gaps_on = 1'b1;
		put_text("x=1");
		char_valid <= 1'b0;

		while (ledger.due_tokens.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (ledger.mismatches == 0 && ledger.due_tokens.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
